### sv/phpa_pkg.sv
package phpa_pkg;

    // Request codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Protocol codes; the last one has no pool
    localparam logic [1:0] PROTO_TCP  = 2'd0;
    localparam logic [1:0] PROTO_UDP  = 2'd1;
    localparam logic [1:0] PROTO_ICMP = 2'd2;
    localparam logic [1:0] PROTO_BAD  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // In-use flags are kept in rows of 32 bits
    localparam int FLAG_ROW_W  = 32;
    localparam int FLAG_ROW_AW = 5;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_start;
        logic scan_step;
        logic new_slot;
        logic pool_rd;
        logic ring_rd;
        logic flag_rd;
        logic alloc_wr;
        logic rel_wr;
        logic set_early;
        logic set_fail;
        logic set_ok_alloc;
        logic set_ok_rel;
        logic out_load;
    } phpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic early;
        logic is_release;
        logic hit;
        logic miss;
        logic table_full;
        logic pool_empty;
        logic flag_set;
        logic out_free;
    } phpa_sts_t;

endpackage

### sv/phpa_ctrl.sv
module phpa_ctrl
    import phpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  phpa_sts_t sts,
    output phpa_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_NEWSLOT = 4'd4;
    localparam logic [3:0] S_POOL    = 4'd5;
    localparam logic [3:0] S_ARING   = 4'd6;
    localparam logic [3:0] S_AFLAG   = 4'd7;
    localparam logic [3:0] S_AWR     = 4'd8;
    localparam logic [3:0] S_RCHK    = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.early)
                begin
                    cmd.set_early = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_POOL;
                end
                else if (sts.miss)
                begin
                    if (sts.is_release || sts.table_full)
                    begin
                        cmd.set_fail = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_NEWSLOT;
                    end
                end
            end
            S_NEWSLOT:
            begin
                cmd.new_slot = 1'b1;
                state_next   = S_POOL;
            end
            S_POOL:
            begin
                cmd.pool_rd = 1'b1;
                state_next  = sts.is_release ? S_RCHK : S_ARING;
            end
            S_ARING:
            begin
                if (sts.pool_empty)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.ring_rd = 1'b1;
                    state_next  = S_AFLAG;
                end
            end
            S_AFLAG:
            begin
                cmd.flag_rd = 1'b1;
                state_next  = S_AWR;
            end
            S_AWR:
            begin
                cmd.alloc_wr     = 1'b1;
                cmd.set_ok_alloc = 1'b1;
                state_next       = S_DONE;
            end
            S_RCHK:
            begin
                if (sts.flag_set)
                begin
                    cmd.rel_wr     = 1'b1;
                    cmd.set_ok_rel = 1'b1;
                end
                else
                begin
                    cmd.set_fail = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### sv/phpa_dp.sv
module phpa_dp
    import phpa_pkg::*;
#(
    parameter int HOSTS          = 16,
    parameter int PORT_SPACE     = 4096,
    parameter int RESERVED_PORTS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  phpa_cmd_t   cmd,
    output phpa_sts_t   sts,
    input  logic        command,
    input  logic [31:0] ip,
    input  logic [1:0]  proto,
    input  logic [15:0] port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] port_res
);

    localparam int SW  = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int CW  = $clog2(HOSTS + 1);
    localparam int PW  = $clog2(PORT_SPACE);
    localparam int NW  = $clog2(PORT_SPACE - RESERVED_PORTS + 1);
    localparam int PLW = SW + 2;
    localparam int FAW = PLW + PW - FLAG_ROW_AW;
    localparam int RAW = PLW + PW;

    typedef struct packed {
        logic          lapped;
        logic [NW-1:0] free_cnt;
        logic [PW-1:0] ret;
        logic [PW-1:0] take;
    } pool_t;

    localparam pool_t POOL_INIT = '{
        lapped:   1'b0,
        free_cnt: NW'(PORT_SPACE - RESERVED_PORTS),
        ret:      PW'(RESERVED_PORTS),
        take:     PW'(RESERVED_PORTS)
    };

    function automatic logic [PW:0] incr_pos(input logic [PW-1:0] p);
        return {1'b0, p} + (PW+1)'(1);
    endfunction

    function automatic logic wraps(input logic [PW-1:0] p);
        return incr_pos(p) >= (PW+1)'(PORT_SPACE);
    endfunction

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        logic [PW:0] n;
        n = incr_pos(p);
        return wraps(p) ? PW'(RESERVED_PORTS) : n[PW-1:0];
    endfunction

    // Request word
    logic        cmd_reg;
    logic [31:0] ip_reg;
    logic [1:0]  proto_reg;
    logic [15:0] port_reg;

    // Host table search
    logic [31:0]   host_mem [HOSTS];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [SW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;
    logic [31:0]   host_rdata_reg;
    logic [SW-1:0] slot_reg;

    // Pool, ring and flag stores
    pool_t                 pool_mem [1 << PLW];
    logic [FLAG_ROW_W-1:0] flag_mem [1 << FAW];
    logic [PW-1:0]         ring_mem [1 << RAW];
    pool_t                 pool_rdata_reg;
    logic [FLAG_ROW_W-1:0] flag_rdata_reg;
    logic [PW-1:0]         ring_rdata_reg;
    logic                  written_reg;
    logic [PW-1:0]         got_reg;
    logic [FAW-1:0]        clr_cnt_reg;

    // Result
    logic [1:0]  res_status_reg;
    logic [15:0] res_port_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] port_res_reg;

    logic                  reject;
    logic                  fail_early;
    logic                  hit;
    logic [PLW-1:0]        pool_idx;
    logic [PW-1:0]         got_next;
    logic [FAW-1:0]        rel_row;
    logic [FAW-1:0]        got_row_next;
    logic [FAW-1:0]        got_row;
    logic [FLAG_ROW_W-1:0] got_mask;
    logic [FLAG_ROW_W-1:0] rel_mask;
    pool_t                 pool_alloc;
    pool_t                 pool_rel;

    logic                  pool_we;
    logic [PLW-1:0]        pool_wa;
    pool_t                 pool_wd;
    logic                  flag_we;
    logic [FAW-1:0]        flag_wa;
    logic [FLAG_ROW_W-1:0] flag_wd;
    logic [FAW-1:0]        flag_ra;

    assign reject = (proto_reg == PROTO_BAD)
                 || (cmd_reg == CMD_ALLOC && ip_reg == '0)
                 || (cmd_reg == CMD_RELEASE && ip_reg == '0
                     && port_reg >= 16'(RESERVED_PORTS));
    assign fail_early = (cmd_reg == CMD_RELEASE)
                     && (port_reg < 16'(RESERVED_PORTS)
                         || {1'b0, port_reg} >= 17'(PORT_SPACE));

    assign hit      = cmp_vld_reg && (host_rdata_reg == ip_reg);
    assign pool_idx = {slot_reg, proto_reg};
    assign got_next = written_reg ? ring_rdata_reg : pool_rdata_reg.take;
    assign rel_row  = {pool_idx, port_reg[PW-1:FLAG_ROW_AW]};
    assign got_row_next = {pool_idx, got_next[PW-1:FLAG_ROW_AW]};
    assign got_row  = {pool_idx, got_reg[PW-1:FLAG_ROW_AW]};
    assign got_mask = FLAG_ROW_W'(1) << got_reg[FLAG_ROW_AW-1:0];
    assign rel_mask = FLAG_ROW_W'(1) << port_reg[FLAG_ROW_AW-1:0];

    always_comb
    begin
        pool_alloc          = pool_rdata_reg;
        pool_alloc.free_cnt = pool_rdata_reg.free_cnt - NW'(1);
        pool_alloc.take     = next_pos(pool_rdata_reg.take);
        pool_rel            = pool_rdata_reg;
        pool_rel.free_cnt   = pool_rdata_reg.free_cnt + NW'(1);
        pool_rel.ret        = next_pos(pool_rdata_reg.ret);
        pool_rel.lapped     = pool_rdata_reg.lapped | wraps(pool_rdata_reg.ret);
    end

    always_comb
    begin
        pool_we = cmd.clr_step || cmd.alloc_wr || cmd.rel_wr;
        pool_wa = cmd.clr_step ? clr_cnt_reg[FAW-1 -: PLW] : pool_idx;
        pool_wd = cmd.clr_step ? POOL_INIT : (cmd.alloc_wr ? pool_alloc : pool_rel);
        flag_we = cmd.clr_step || cmd.alloc_wr || cmd.rel_wr;
        flag_wa = cmd.clr_step ? clr_cnt_reg : (cmd.alloc_wr ? got_row : rel_row);
        if (cmd.clr_step)
        begin
            flag_wd = '0;
        end
        else if (cmd.alloc_wr)
        begin
            flag_wd = flag_rdata_reg | got_mask;
        end
        else
        begin
            flag_wd = flag_rdata_reg & ~rel_mask;
        end
        flag_ra = cmd.flag_rd ? got_row_next : rel_row;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.new_slot)
        begin
            host_mem[count_reg[SW-1:0]] <= ip_reg;
        end
        if (cmd.scan_step)
        begin
            host_rdata_reg <= host_mem[scan_idx_reg[SW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_wa] <= pool_wd;
        end
        if (cmd.pool_rd)
        begin
            pool_rdata_reg <= pool_mem[pool_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        if (cmd.pool_rd || cmd.flag_rd)
        begin
            flag_rdata_reg <= flag_mem[flag_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rel_wr)
        begin
            ring_mem[{pool_idx, pool_rdata_reg.ret}] <= port_reg[PW-1:0];
        end
        if (cmd.ring_rd)
        begin
            ring_rdata_reg <= ring_mem[{pool_idx, pool_rdata_reg.take}];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            ip_reg    <= ip;
            proto_reg <= proto;
            port_reg  <= port;
        end
        if (cmd.scan_step && hit)
        begin
            slot_reg <= cmp_idx_reg;
        end
        else if (cmd.new_slot)
        begin
            slot_reg <= count_reg[SW-1:0];
        end
        if (cmd.scan_step)
        begin
            cmp_idx_reg <= scan_idx_reg[SW-1:0];
        end
        if (cmd.ring_rd)
        begin
            // entries not yet reached by the return index still hold their position
            written_reg <= pool_rdata_reg.lapped
                        || (pool_rdata_reg.take < pool_rdata_reg.ret);
        end
        if (cmd.flag_rd)
        begin
            got_reg <= got_next;
        end
        if (cmd.set_early)
        begin
            res_status_reg <= reject ? ST_REJECT : ST_FAIL;
            res_port_reg   <= '0;
        end
        else if (cmd.set_fail)
        begin
            res_status_reg <= ST_FAIL;
            res_port_reg   <= '0;
        end
        else if (cmd.set_ok_alloc)
        begin
            res_status_reg <= ST_OK;
            res_port_reg   <= 16'(got_reg);
        end
        else if (cmd.set_ok_rel)
        begin
            res_status_reg <= ST_OK;
            res_port_reg   <= '0;
        end
        if (cmd.out_load)
        begin
            status_reg   <= res_status_reg;
            port_res_reg <= res_port_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + FAW'(1);
            end
            if (cmd.new_slot)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                cmp_vld_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                cmp_vld_reg <= (scan_idx_reg < count_reg);
                if (scan_idx_reg < count_reg)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_last   = &clr_cnt_reg;
        sts.early      = reject || fail_early;
        sts.is_release = (cmd_reg == CMD_RELEASE);
        sts.hit        = hit;
        sts.miss       = !hit && (scan_idx_reg == count_reg);
        sts.table_full = (count_reg == CW'(HOSTS));
        sts.pool_empty = (pool_rdata_reg.free_cnt == '0);
        sts.flag_set   = flag_rdata_reg[port_reg[FLAG_ROW_AW-1:0]];
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign port_res  = port_res_reg;

endmodule

### sv/per_host_port_allocator_core.sv
// Channel   Direction  Handshake            Word
// request   in         in_valid/in_ready    command, ip, proto, port
// result    out        out_valid/out_ready  status, port_res
//
// One request at a time. A request settled by its own fields (bad protocol,
// zero address, port outside the pool range) goes straight to its result;
// a release or an allocate first searches the host table slot by slot
// through its single read port, and an allocate for a new host then takes
// a new slot.
// After reset the in-use flags and pool indices are swept clean, one 32-flag
// row per cycle; in_ready stays low meanwhile.
// A result held by out_ready low does not block the next request; only the
// one after it waits until the result register is free.
module per_host_port_allocator_core
    import phpa_pkg::*;
#(
    parameter int HOSTS          = 16,
    parameter int PORT_SPACE     = 4096,
    parameter int RESERVED_PORTS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] ip,
    input  logic [1:0]  proto,
    input  logic [15:0] port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] port_res
);

    // Command and status between sequencer and datapath
    phpa_cmd_t cmd;
    phpa_sts_t sts;

    // Sequencer: clear sweep, host search, pool read-modify-write
    phpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: host table, pool state, free rings, in-use flags, result word
    phpa_dp #(
        .HOSTS          (HOSTS),
        .PORT_SPACE     (PORT_SPACE),
        .RESERVED_PORTS (RESERVED_PORTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .command   (command),
        .ip        (ip),
        .proto     (proto),
        .port      (port),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .port_res  (port_res)
    );

    // Drop ready right after a request word is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_FAIL || status == ST_REJECT))
        else $error("result with undefined status code");

    a_fail_zero_port: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (port_res == '0))
        else $error("failed request carries a port");

    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK && port_res != '0)
            |-> (port_res >= 16'(RESERVED_PORTS)
                 && {1'b0, port_res} < 17'(PORT_SPACE)))
        else $error("allocated port outside pool range");

endmodule

### dv/tb_per_host_port_allocator_core.sv
`timescale 1ns / 1ps

module tb_per_host_port_allocator_core
    import phpa_pkg::*;
();

    // Block sizes at their defaults
    localparam int N_HOSTS    = 16;
    localparam int N_PORTS    = 4096;
    localparam int RSV        = 1024;
    localparam int N_PROTO    = 3;
    localparam int N_POOLS    = N_HOSTS * N_PROTO;
    localparam int N_ENTRIES  = N_POOLS * N_PORTS;

    // Cycles with no word moving on either channel before giving up; the
    // limit also covers the flag sweep after reset
    localparam int STALL_LIMIT = 30000;

    // Number of host addresses used by the random part; more than the
    // table holds so that a full table is reached
    localparam int N_TEST_HOSTS = 24;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port_res;
    } reply_t;

    // {ip, proto, port} of a port that is currently handed out
    typedef logic [49:0] grant_key_t;

    // Tracks the allocator state and the replies still owed by the block
    class alloc_scoreboard;
        logic [31:0] slot_ip [N_HOSTS];
        int unsigned slot_count;
        logic [15:0] ring_port [N_ENTRIES];
        bit          ring_ok [N_ENTRIES];
        bit          port_busy [N_ENTRIES];
        int unsigned take_pos [N_POOLS];
        int unsigned give_pos [N_POOLS];
        reply_t      queued_replies [$];
        grant_key_t  granted_ports [$];
        int          errors;

        function new();
            slot_count = 0;
            errors     = 0;
            for (int p = 0; p < N_POOLS; p++)
            begin
                take_pos[p] = RSV;
                give_pos[p] = RSV;
            end
            for (int e = 0; e < N_ENTRIES; e++)
            begin
                ring_port[e] = 16'(e % N_PORTS);
                ring_ok[e]   = (e % N_PORTS) >= RSV;
                port_busy[e] = 1'b0;
            end
        endfunction

        function int find_slot(logic [31:0] a);
            for (int i = 0; i < int'(slot_count); i++)
            begin
                if (slot_ip[i] == a)
                    return i;
            end
            return -1;
        endfunction

        function int unsigned wrap_next(int unsigned pos);
            return (pos + 1 >= N_PORTS) ? RSV : pos + 1;
        endfunction

        // Apply one accepted request to the state and queue the reply it owes
        function void note_request(logic cmd, logic [31:0] a, logic [1:0] pr,
                                   logic [15:0] pt);
            reply_t     r;
            int         slot;
            int         pool;
            int         e;
            int         f;
            grant_key_t key;
            int         hit [$];
            r.status   = ST_FAIL;
            r.port_res = '0;
            if (pr == PROTO_BAD)
                r.status = ST_REJECT;
            else if (cmd == CMD_ALLOC)
            begin
                if (a == 32'd0)
                    r.status = ST_REJECT;
                else
                begin
                    slot = find_slot(a);
                    if (slot < 0 && slot_count < N_HOSTS)
                    begin
                        slot_ip[slot_count] = a;
                        slot = int'(slot_count);
                        slot_count++;
                    end
                    if (slot >= 0)
                    begin
                        pool = slot * N_PROTO + int'(pr);
                        e    = pool * N_PORTS + int'(take_pos[pool]);
                        if (ring_ok[e])
                        begin
                            ring_ok[e]     = 1'b0;
                            take_pos[pool] = wrap_next(take_pos[pool]);
                            port_busy[pool * N_PORTS + int'(ring_port[e])] = 1'b1;
                            r.status   = ST_OK;
                            r.port_res = ring_port[e];
                            granted_ports.push_back({a, pr, ring_port[e]});
                        end
                    end
                end
            end
            else if (pt < RSV)
                r.status = ST_FAIL;
            else if (a == 32'd0)
                r.status = ST_REJECT;
            else
            begin
                slot = find_slot(a);
                if (slot >= 0 && pt < N_PORTS)
                begin
                    pool = slot * N_PROTO + int'(pr);
                    f    = pool * N_PORTS + int'(pt);
                    if (port_busy[f])
                    begin
                        e              = pool * N_PORTS + int'(give_pos[pool]);
                        port_busy[f]   = 1'b0;
                        ring_port[e]   = pt;
                        ring_ok[e]     = 1'b1;
                        give_pos[pool] = wrap_next(give_pos[pool]);
                        r.status       = ST_OK;
                        key = {a, pr, pt};
                        hit = granted_ports.find_first_index(item) with (item == key);
                        if (hit.size() != 0)
                            granted_ports.delete(hit[0]);
                    end
                end
            end
            queued_replies.push_back(r);
        endfunction

        // Compare one result word with the oldest owed reply
        function void check_reply(logic [1:0] st, logic [15:0] pr);
            reply_t want;
            if (queued_replies.size() == 0)
            begin
                $display("%0t: result with nothing owed, expected none, actual status %0d port %0d",
                         $time, st, pr);
                errors++;
                return;
            end
            want = queued_replies.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, st);
                errors++;
            end
            if (pr !== want.port_res)
            begin
                $display("%0t: port_res mismatch, expected %0d, actual %0d",
                         $time, want.port_res, pr);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        command   = CMD_ALLOC;
    logic [31:0] ip        = '0;
    logic [1:0]  proto     = PROTO_TCP;
    logic [15:0] port      = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [15:0] port_res;

    alloc_scoreboard sb;

    // Idle odds in percent; the sink one changes by nonblocking assignment
    // so that the receiver always block sees it at a fixed point of the edge
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_cycles  = 0;

    logic [31:0] host_pool [N_TEST_HOSTS];

    per_host_port_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .ip        (ip),
        .proto     (proto),
        .port      (port),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .port_res  (port_res)
    );

    always #5 clk = ~clk;

    // Receiver: stall at random with the current odds
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Check each result word and watch for a hung block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(status, port_res);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one request word and hold it until the block takes it. Call right
    // after a rising edge; returns right after the accepting edge.
    task automatic send_word(input logic cmd, input logic [31:0] a,
                             input logic [1:0] pr, input logic [15:0] pt);
        // Insert idle cycles ahead of the word at the sender's odds
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        ip       <= a;
        proto    <= pr;
        port     <= pt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(cmd, a, pr, pt);
    endtask

    // Mostly well-formed traffic: allocations on a known host set and
    // releases of ports that are really out, with some malformed words mixed in
    task automatic random_traffic(input int count);
        int          kind;
        int          pick;
        logic [31:0] a;
        logic [1:0]  pr;
        grant_key_t  key;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            // Favor the first half of the address set so that those hosts get deep
            pick = ($urandom_range(0, 99) < 85) ? $urandom_range(0, N_TEST_HOSTS / 2 - 1)
                                                : $urandom_range(0, N_TEST_HOSTS - 1);
            a  = host_pool[pick];
            pr = 2'($urandom_range(0, N_PROTO - 1));
            if (kind < 85 && kind >= 55 && sb.granted_ports.size() != 0)
            begin
                // Return a port that is out right now
                key = sb.granted_ports[$urandom_range(0, sb.granted_ports.size() - 1)];
                send_word(CMD_RELEASE, key[49:18], key[17:16], key[15:0]);
            end
            else if (kind < 85)
                send_word(CMD_ALLOC, a, pr, 16'($urandom));
            else
            begin
                case ($urandom_range(0, 5))
                    0: send_word(1'($urandom), a, PROTO_BAD, 16'($urandom));
                    1: send_word(1'($urandom), 32'd0, pr, 16'($urandom));
                    2: send_word(CMD_RELEASE, a, pr, 16'($urandom_range(0, RSV - 1)));
                    3: send_word(CMD_RELEASE, a, pr, 16'($urandom_range(N_PORTS, 65535)));
                    // Likely a port that is not out, or one already returned
                    4: send_word(CMD_RELEASE, a, pr, 16'($urandom_range(RSV, N_PORTS - 1)));
                    default: send_word(1'($urandom), $urandom, 2'($urandom), 16'($urandom));
                endcase
            end
        end
    endtask

    initial
    begin
        logic [31:0] top_ip;
        logic [31:0] low_ip;

        sb       = new();
        top_ip   = 32'hFFFF_FFFF;
        low_ip   = 32'h0000_0001;
        for (int i = 0; i < N_TEST_HOSTS; i++)
        begin
            host_pool[i] = $urandom;
            if (host_pool[i] == 32'd0)
                host_pool[i] = 32'h8000_0000;
        end

        // Hold reset, then release it once for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct   = 33;
        sink_idle_pct <= 63;

        // Directed: first grants on every protocol for the all-ones host
        send_word(CMD_ALLOC, top_ip, PROTO_TCP, 16'h0000);
        send_word(CMD_ALLOC, top_ip, PROTO_UDP, 16'hFFFF);
        send_word(CMD_ALLOC, top_ip, PROTO_ICMP, 16'h1234);
        // Unsupported protocol on both commands
        send_word(CMD_ALLOC, top_ip, PROTO_BAD, 16'h0000);
        send_word(CMD_RELEASE, top_ip, PROTO_BAD, 16'd1024);
        // Zero address; on a release below the reserved range the range
        // check wins over the address check
        send_word(CMD_ALLOC, 32'd0, PROTO_TCP, 16'h0000);
        send_word(CMD_RELEASE, 32'd0, PROTO_TCP, 16'd2000);
        send_word(CMD_RELEASE, 32'd0, PROTO_UDP, 16'd5);
        // Release edges of the pool range
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd0);
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd1023);
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd4096);
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'hFFFF);
        // Release for a host with no slot must not take one
        send_word(CMD_RELEASE, low_ip, PROTO_TCP, 16'd1024);
        // Port in range but never handed out
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd1025);
        // Good release, then the same port again
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd1024);
        send_word(CMD_RELEASE, top_ip, PROTO_TCP, 16'd1024);
        send_word(CMD_ALLOC, low_ip, PROTO_TCP, 16'hFFFF);
        send_word(CMD_ALLOC, top_ip, PROTO_TCP, 16'h0000);
        send_word(CMD_RELEASE, top_ip, PROTO_ICMP, 16'd1024);
        send_word(CMD_RELEASE, top_ip, PROTO_UDP, 16'd1024);
        send_word(CMD_ALLOC, top_ip, PROTO_ICMP, 16'h0000);

        // Random traffic under three idle patterns
        random_traffic(293);
        src_idle_pct   = 63;
        sink_idle_pct <= 33;
        random_traffic(293);
        src_idle_pct   = 0;
        sink_idle_pct <= 0;
        random_traffic(293);
        in_valid <= 1'b0;

        // Drain the owed replies, then give a late stray word time to show
        while (sb.queued_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### per_host_port_allocator_core.f
sv/phpa_pkg.sv
sv/phpa_ctrl.sv
sv/phpa_dp.sv
sv/per_host_port_allocator_core.sv
dv/tb_per_host_port_allocator_core.sv
